### sv/four_axis_stepper_pulse_controller_top_assert.svh
// Assertion macros for the stepper pulse controller top level.
`ifndef FOUR_AXIS_STEPPER_PULSE_CONTROLLER_TOP_ASSERT_SVH
`define FOUR_AXIS_STEPPER_PULSE_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spc: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spc: next-cycle check failed");

`endif

### sv/spc_pkg.sv
package spc_pkg;

  localparam int AXES         = 4;
  localparam int AXIS_BITS    = $clog2(AXES);
  localparam int COUNT_BITS   = 20;
  localparam int TIME_BITS    = 16;
  localparam int DELTA_BITS   = 16;
  localparam int PROD_BITS    = TIME_BITS + DELTA_BITS;
  localparam int DIV_CNT_BITS = $clog2(PROD_BITS);

  localparam int CFG_BITS     = 20;
  localparam int CFG_IDX_BITS = 2;

  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  localparam logic [TIME_BITS-1:0]  TIME_MAX         = '1;
  localparam logic [TIME_BITS-1:0]  MIN_PERIOD_RST   = TIME_BITS'(500);
  localparam logic [TIME_BITS-1:0]  PULSE_HIGH_RST   = TIME_BITS'(10);
  localparam logic [TIME_BITS-1:0]  FAST_PERIOD_RST  = TIME_BITS'(300);
  localparam logic [COUNT_BITS-1:0] HOMING_COUNT_RST = COUNT_BITS'(100000);

  localparam logic [AXIS_BITS-1:0] AXIS_X = AXIS_BITS'(0);
  localparam logic [AXIS_BITS-1:0] AXIS_Y = AXIS_BITS'(1);
  localparam logic [AXIS_BITS-1:0] AXIS_Z = AXIS_BITS'(2);

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_MOVE  = 3'd1,
    OP_RUN   = 3'd2,
    OP_STOP  = 3'd3,
    OP_LIMIT = 3'd4,
    OP_HOME  = 3'd5,
    OP_CLEAR = 3'd6,
    OP_NONE  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    MODE_RUN    = 2'd0,
    MODE_HOMING = 2'd1,
    MODE_HOMED  = 2'd2,
    MODE_ERROR  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MIN_PERIOD   = 2'd0,
    REG_PULSE_HIGH   = 2'd1,
    REG_FAST_PERIOD  = 2'd2,
    REG_HOMING_COUNT = 2'd3
  } cfg_reg_t;

  // Decoded item as it sits in the queue.
  typedef struct packed {
    op_t                    kind;
    logic [AXIS_BITS-1:0]   axis;
    logic                   direction;
    logic [COUNT_BITS-1:0]  count;
    logic [TIME_BITS-1:0]   period;
    logic                   pressed;
    logic [DELTA_BITS-1:0]  mag_x;
    logic [DELTA_BITS-1:0]  mag_y;
    logic                   dir_x;
    logic                   dir_y;
    logic                   empty_move;
    logic                   div_need;
    logic                   div_x;
    logic [DELTA_BITS-1:0]  larger;
    logic [DELTA_BITS-1:0]  smaller;
  } cmd_t;

  typedef struct packed {
    logic                  valid;
    logic                  full;
    logic [Q_CNT_BITS-1:0] count;
  } q_stat_t;

endpackage

### sv/four_axis_stepper_pulse_controller_top.sv
// An accepted item is queued, then executed into the output register; an xy move
// whose axes differ first passes the radix-2 divider: multiply, divide, apply.
// One item per cycle while no divide is needed and the output is not stalled.
// Accepts the next item while a result waits: two-entry queue plus output register.
// Reset (rst_n low, synchronous): queue and output empty, axis state cleared,
// registers back to their reset values, mode guarded run.
`include "four_axis_stepper_pulse_controller_top_assert.svh"

module four_axis_stepper_pulse_controller_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [2:0]                             in_op,
  input  logic signed [spc_pkg::DELTA_BITS-1:0]  in_delta_x,
  input  logic signed [spc_pkg::DELTA_BITS-1:0]  in_delta_y,
  input  logic [spc_pkg::AXIS_BITS-1:0]          in_axis,
  input  logic                                   in_direction,
  input  logic [spc_pkg::COUNT_BITS-1:0]         in_count,
  input  logic [spc_pkg::TIME_BITS-1:0]          in_period,
  input  logic                                   in_switch_level,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [spc_pkg::AXES-1:0]               out_step_lines,
  output logic [spc_pkg::AXES-1:0]               out_direction_lines,
  output logic [spc_pkg::AXES-1:0]               out_enable_lines,
  output logic [1:0]                             out_mode,
  output logic                                   out_xy_busy,
  output logic                                   out_all_idle,
  input  logic                                   cfg_we,
  input  logic [spc_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [spc_pkg::CFG_BITS-1:0]           cfg_data
);

  spc_pkg::q_stat_t q_stat;
  spc_pkg::cmd_t    push_cmd;
  spc_pkg::cmd_t    head;
  logic             q_push;
  logic             q_pop;
  logic             err_shown;

  spc_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_delta_x      (in_delta_x),
    .in_delta_y      (in_delta_y),
    .in_axis         (in_axis),
    .in_direction    (in_direction),
    .in_count        (in_count),
    .in_period       (in_period),
    .in_switch_level (in_switch_level),
    .q_stat          (q_stat),
    .push            (q_push),
    .push_cmd        (push_cmd)
  );

  spc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  spc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .head                (head),
    .q_stat              (q_stat),
    .pop                 (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_step_lines      (out_step_lines),
    .out_direction_lines (out_direction_lines),
    .out_enable_lines    (out_enable_lines),
    .out_mode            (out_mode),
    .out_xy_busy         (out_xy_busy),
    .out_all_idle        (out_all_idle)
  );

  assign err_shown = out_valid && (out_mode == spc_pkg::MODE_ERROR);

  `SPC_ASSERT_IMP(a_busy_not_idle, out_valid, !(out_xy_busy && out_all_idle))
  `SPC_ASSERT_IMP(a_error_quiet, err_shown, out_enable_lines == '0 && out_all_idle)
  `SPC_ASSERT_IMP(a_pop_nonempty, q_pop, q_stat.count != '0)
  `SPC_ASSERT_NXT(a_fill_by_push, !q_push, !$fell(in_ready))

endmodule

### sv/spc_front.sv
module spc_front (
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       in_op,
  input  logic signed [spc_pkg::DELTA_BITS-1:0] in_delta_x,
  input  logic signed [spc_pkg::DELTA_BITS-1:0] in_delta_y,
  input  logic [spc_pkg::AXIS_BITS-1:0]    in_axis,
  input  logic                             in_direction,
  input  logic [spc_pkg::COUNT_BITS-1:0]   in_count,
  input  logic [spc_pkg::TIME_BITS-1:0]    in_period,
  input  logic                             in_switch_level,
  input  spc_pkg::q_stat_t                 q_stat,
  output logic                             push,
  output spc_pkg::cmd_t                    push_cmd
);

  logic [spc_pkg::DELTA_BITS-1:0] dx;
  logic [spc_pkg::DELTA_BITS-1:0] dy;
  logic [spc_pkg::DELTA_BITS-1:0] sx;
  logic [spc_pkg::DELTA_BITS-1:0] sy;
  logic                           y_gt_x;
  logic                           x_gt_y;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  assign dx = $unsigned(in_delta_x);
  assign dy = $unsigned(in_delta_y);
  // two's complement magnitude; the most negative value maps to itself
  assign sx = dx[spc_pkg::DELTA_BITS-1] ? (~dx + 1'b1) : dx;
  assign sy = dy[spc_pkg::DELTA_BITS-1] ? (~dy + 1'b1) : dy;
  assign y_gt_x = sy > sx;
  assign x_gt_y = sx > sy;

  always_comb begin
    push_cmd            = '0;
    push_cmd.kind       = spc_pkg::op_t'(in_op);
    push_cmd.axis       = in_axis;
    push_cmd.direction  = in_direction;
    push_cmd.count      = in_count;
    push_cmd.period     = in_period;
    push_cmd.pressed    = in_switch_level;
    push_cmd.mag_x      = sx;
    push_cmd.mag_y      = sy;
    push_cmd.dir_x      = dx[spc_pkg::DELTA_BITS-1] || (sx == '0);
    push_cmd.dir_y      = dy[spc_pkg::DELTA_BITS-1] || (sy == '0);
    push_cmd.empty_move = (sx == '0) && (sy == '0);
    // slower axis gets a stretched period only when both axes move
    push_cmd.div_need   = (y_gt_x && (sx != '0)) || (x_gt_y && (sy != '0));
    push_cmd.div_x      = y_gt_x;
    push_cmd.larger     = y_gt_x ? sy : sx;
    push_cmd.smaller    = y_gt_x ? sx : sy;
  end

endmodule

### sv/spc_queue.sv
module spc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  spc_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output spc_pkg::cmd_t    head,
  output spc_pkg::q_stat_t q_stat
);

  spc_pkg::cmd_t                    mem_r [spc_pkg::Q_DEPTH];
  logic [spc_pkg::Q_PTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [spc_pkg::Q_PTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [spc_pkg::Q_CNT_BITS-1:0]   cnt_r, cnt_nxt;

  localparam logic [spc_pkg::Q_PTR_BITS-1:0] PTR_LAST =
    spc_pkg::Q_PTR_BITS'(spc_pkg::Q_DEPTH - 1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.valid = cnt_r != '0;
  assign q_stat.full  = cnt_r == spc_pkg::Q_CNT_BITS'(spc_pkg::Q_DEPTH);
  assign q_stat.count = cnt_r;

endmodule

### sv/spc_back.sv
module spc_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [spc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [spc_pkg::CFG_BITS-1:0]     cfg_data,
  input  spc_pkg::cmd_t                    head,
  input  spc_pkg::q_stat_t                 q_stat,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [spc_pkg::AXES-1:0]         out_step_lines,
  output logic [spc_pkg::AXES-1:0]         out_direction_lines,
  output logic [spc_pkg::AXES-1:0]         out_enable_lines,
  output logic [1:0]                       out_mode,
  output logic                             out_xy_busy,
  output logic                             out_all_idle
);

  localparam int AXES = spc_pkg::AXES;
  localparam int CB   = spc_pkg::COUNT_BITS;
  localparam int TB   = spc_pkg::TIME_BITS;
  localparam int DB   = spc_pkg::DELTA_BITS;
  localparam int PB   = spc_pkg::PROD_BITS;

  typedef enum logic [3:0] {
    ST_EXEC  = 4'b0001,
    ST_MUL   = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_APPLY = 4'b1000
  } st_t;

  // configuration
  logic [TB-1:0] min_period_r, pulse_high_r, fast_period_r;
  logic [CB-1:0] homing_count_r;

  // sequencer and divider
  st_t                              st_r, st_nxt;
  spc_pkg::cmd_t                    cmd_r, cmd_nxt;
  logic [PB-1:0]                    quo_r, quo_nxt;
  logic [DB-1:0]                    rem_r, rem_nxt;
  logic [spc_pkg::DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;

  // axis state
  logic [CB-1:0]      wanted_r  [AXES];
  logic [CB-1:0]      wanted_nxt[AXES];
  logic [CB-1:0]      issued_r  [AXES];
  logic [CB-1:0]      issued_nxt[AXES];
  logic [TB-1:0]      period_r  [AXES];
  logic [TB-1:0]      period_nxt[AXES];
  logic [TB-1:0]      elapsed_r [AXES];
  logic [TB-1:0]      elapsed_nxt[AXES];
  logic [AXES-1:0]    rtr_r, rtr_nxt;
  logic [AXES-1:0]    step_r, step_nxt;
  logic [AXES-1:0]    dir_r, dir_nxt;
  logic [AXES-1:0]    en_r, en_nxt;
  spc_pkg::mode_t     mode_r, mode_nxt;

  // output register
  logic               out_valid_r;
  logic [AXES-1:0]    out_step_r, out_dir_r, out_en_r;
  spc_pkg::mode_t     out_mode_r;
  logic               out_busy_r, out_idle_r;

  logic               slot_free;
  logic               err;
  logic               head_div;
  logic               exec_en;
  spc_pkg::cmd_t      ex_cmd;
  logic [TB-1:0]      div_sat;
  logic [TB-1:0]      px, py;
  logic [DB:0]        trial;
  logic [DB:0]        diff;
  logic               ge;
  logic [AXES-1:0]    pend;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_period_r   <= spc_pkg::MIN_PERIOD_RST;
      pulse_high_r   <= spc_pkg::PULSE_HIGH_RST;
      fast_period_r  <= spc_pkg::FAST_PERIOD_RST;
      homing_count_r <= spc_pkg::HOMING_COUNT_RST;
    end else if (cfg_we) begin
      case (spc_pkg::cfg_reg_t'(cfg_index))
        spc_pkg::REG_MIN_PERIOD:   min_period_r   <= cfg_data[TB-1:0];
        spc_pkg::REG_PULSE_HIGH:   pulse_high_r   <= cfg_data[TB-1:0];
        spc_pkg::REG_FAST_PERIOD:  fast_period_r  <= cfg_data[TB-1:0];
        spc_pkg::REG_HOMING_COUNT: homing_count_r <= cfg_data[CB-1:0];
        default: ;
      endcase
    end
  end

  assign slot_free = !out_valid_r || out_ready;
  assign err       = mode_r == spc_pkg::MODE_ERROR;
  assign head_div  = (head.kind == spc_pkg::OP_MOVE) && !err && head.div_need;
  assign ex_cmd    = (st_r == ST_APPLY) ? cmd_r : head;

  assign div_sat = (|quo_r[PB-1:TB]) ? spc_pkg::TIME_MAX : quo_r[TB-1:0];
  assign px = (st_r == ST_APPLY &&  cmd_r.div_x) ? div_sat : min_period_r;
  assign py = (st_r == ST_APPLY && !cmd_r.div_x) ? div_sat : min_period_r;

  // restoring divide, one quotient bit per cycle
  assign trial = {rem_r, quo_r[PB-1]};
  assign diff  = trial - {1'b0, cmd_r.smaller};
  assign ge    = trial >= {1'b0, cmd_r.smaller};

  always_comb begin
    st_nxt  = st_r;
    cmd_nxt = cmd_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    pop     = 1'b0;
    exec_en = 1'b0;
    case (st_r)
      ST_EXEC: begin
        if (q_stat.valid && slot_free) begin
          pop = 1'b1;
          if (head_div) begin
            cmd_nxt = head;
            st_nxt  = ST_MUL;
          end else begin
            exec_en = 1'b1;
          end
        end
      end
      ST_MUL: begin
        quo_nxt = PB'(min_period_r) * PB'(cmd_r.larger);
        rem_nxt = '0;
        cnt_nxt = '0;
        st_nxt  = ST_DIV;
      end
      ST_DIV: begin
        quo_nxt = {quo_r[PB-2:0], ge};
        rem_nxt = ge ? diff[DB-1:0] : trial[DB-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == spc_pkg::DIV_CNT_BITS'(PB - 1)) begin
          st_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        // output slot was emptied when this item left the queue
        exec_en = 1'b1;
        st_nxt  = ST_EXEC;
      end
      default: st_nxt = ST_EXEC;
    endcase
  end

  always_comb begin
    logic [TB-1:0] tick_e;
    wanted_nxt  = wanted_r;
    issued_nxt  = issued_r;
    period_nxt  = period_r;
    elapsed_nxt = elapsed_r;
    rtr_nxt     = rtr_r;
    step_nxt    = step_r;
    dir_nxt     = dir_r;
    en_nxt      = en_r;
    mode_nxt    = mode_r;
    tick_e      = '0;
    if (exec_en) begin
      case (ex_cmd.kind)
        spc_pkg::OP_TICK: begin
          for (int a = 0; a < AXES; a++) begin
            tick_e = (elapsed_r[a] == spc_pkg::TIME_MAX) ? elapsed_r[a]
                                                         : elapsed_r[a] + 1'b1;
            elapsed_nxt[a] = tick_e;
            if ((issued_r[a] < wanted_r[a]) && (tick_e > pulse_high_r)) begin
              if (rtr_r[a]) begin
                rtr_nxt[a]     = 1'b0;
                elapsed_nxt[a] = '0;
                step_nxt[a]    = 1'b1;
                issued_nxt[a]  = issued_r[a] + 1'b1;
              end else if (tick_e > period_r[a]) begin
                rtr_nxt[a]     = 1'b1;
                elapsed_nxt[a] = '0;
                step_nxt[a]    = 1'b0;
              end
            end
          end
        end
        spc_pkg::OP_MOVE: begin
          if (!err && !ex_cmd.empty_move) begin
            en_nxt[spc_pkg::AXIS_X]     = 1'b1;
            dir_nxt[spc_pkg::AXIS_X]    = ex_cmd.dir_x;
            wanted_nxt[spc_pkg::AXIS_X] = CB'(ex_cmd.mag_x);
            issued_nxt[spc_pkg::AXIS_X] = '0;
            period_nxt[spc_pkg::AXIS_X] = px;
            en_nxt[spc_pkg::AXIS_Y]     = 1'b1;
            dir_nxt[spc_pkg::AXIS_Y]    = ex_cmd.dir_y;
            wanted_nxt[spc_pkg::AXIS_Y] = CB'(ex_cmd.mag_y);
            issued_nxt[spc_pkg::AXIS_Y] = '0;
            period_nxt[spc_pkg::AXIS_Y] = py;
          end
        end
        spc_pkg::OP_RUN: begin
          if (!err) begin
            en_nxt[ex_cmd.axis]     = 1'b1;
            dir_nxt[ex_cmd.axis]    = ex_cmd.direction;
            wanted_nxt[ex_cmd.axis] = ex_cmd.count;
            issued_nxt[ex_cmd.axis] = '0;
            period_nxt[ex_cmd.axis] = ex_cmd.period;
          end
        end
        spc_pkg::OP_STOP: begin
          wanted_nxt[ex_cmd.axis] = '0;
          issued_nxt[ex_cmd.axis] = '0;
          en_nxt[ex_cmd.axis]     = 1'b0;
        end
        spc_pkg::OP_LIMIT: begin
          if (ex_cmd.pressed) begin
            if (mode_r == spc_pkg::MODE_HOMING) begin
              // homing chain: x limit hands over to y, y to z, z finishes
              if (ex_cmd.axis == spc_pkg::AXIS_X) begin
                wanted_nxt[spc_pkg::AXIS_X] = '0;
                issued_nxt[spc_pkg::AXIS_X] = '0;
                en_nxt[spc_pkg::AXIS_X]     = 1'b0;
                en_nxt[spc_pkg::AXIS_Y]     = 1'b1;
                dir_nxt[spc_pkg::AXIS_Y]    = 1'b1;
                wanted_nxt[spc_pkg::AXIS_Y] = homing_count_r;
                issued_nxt[spc_pkg::AXIS_Y] = '0;
                period_nxt[spc_pkg::AXIS_Y] = fast_period_r;
              end else if (ex_cmd.axis == spc_pkg::AXIS_Y) begin
                wanted_nxt[spc_pkg::AXIS_Y] = '0;
                issued_nxt[spc_pkg::AXIS_Y] = '0;
                en_nxt[spc_pkg::AXIS_Y]     = 1'b0;
                en_nxt[spc_pkg::AXIS_Z]     = 1'b1;
                dir_nxt[spc_pkg::AXIS_Z]    = 1'b1;
                wanted_nxt[spc_pkg::AXIS_Z] = homing_count_r;
                issued_nxt[spc_pkg::AXIS_Z] = '0;
                period_nxt[spc_pkg::AXIS_Z] = fast_period_r;
              end else if (ex_cmd.axis == spc_pkg::AXIS_Z) begin
                wanted_nxt[spc_pkg::AXIS_Z] = '0;
                issued_nxt[spc_pkg::AXIS_Z] = '0;
                en_nxt[spc_pkg::AXIS_Z]     = 1'b0;
                mode_nxt                    = spc_pkg::MODE_HOMED;
              end
            end else if (mode_r == spc_pkg::MODE_RUN) begin
              mode_nxt = spc_pkg::MODE_ERROR;
              for (int a = 0; a < AXES; a++) begin
                wanted_nxt[a] = '0;
                issued_nxt[a] = '0;
              end
              en_nxt = '0;
            end
          end
        end
        spc_pkg::OP_HOME: begin
          if (!err) begin
            mode_nxt                    = spc_pkg::MODE_HOMING;
            en_nxt[spc_pkg::AXIS_X]     = 1'b1;
            dir_nxt[spc_pkg::AXIS_X]    = 1'b0;
            wanted_nxt[spc_pkg::AXIS_X] = homing_count_r;
            issued_nxt[spc_pkg::AXIS_X] = '0;
            period_nxt[spc_pkg::AXIS_X] = fast_period_r;
          end
        end
        spc_pkg::OP_CLEAR: begin
          if (err) begin
            mode_nxt = spc_pkg::MODE_RUN;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      pend[a] = issued_nxt[a] < wanted_nxt[a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_EXEC;
      mode_r  <= spc_pkg::MODE_RUN;
      rtr_r   <= '1;
      step_r  <= '0;
      dir_r   <= '0;
      en_r    <= '0;
      for (int a = 0; a < AXES; a++) begin
        wanted_r[a]  <= '0;
        issued_r[a]  <= '0;
        period_r[a]  <= spc_pkg::MIN_PERIOD_RST;
        elapsed_r[a] <= '0;
      end
    end else begin
      st_r      <= st_nxt;
      mode_r    <= mode_nxt;
      rtr_r     <= rtr_nxt;
      step_r    <= step_nxt;
      dir_r     <= dir_nxt;
      en_r      <= en_nxt;
      wanted_r  <= wanted_nxt;
      issued_r  <= issued_nxt;
      period_r  <= period_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_en) begin
      out_step_r <= step_nxt;
      out_dir_r  <= dir_nxt;
      out_en_r   <= en_nxt;
      out_mode_r <= mode_nxt;
      out_busy_r <= pend[spc_pkg::AXIS_X] || pend[spc_pkg::AXIS_Y];
      out_idle_r <= !(|pend);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_step_lines      = out_step_r;
  assign out_direction_lines = out_dir_r;
  assign out_enable_lines    = out_en_r;
  assign out_mode            = out_mode_r;
  assign out_xy_busy         = out_busy_r;
  assign out_all_idle        = out_idle_r;

endmodule

### tb/sv/tb_top.sv
module tb_top;

  localparam int AXES         = spc_pkg::AXES;
  localparam int AXIS_BITS    = spc_pkg::AXIS_BITS;
  localparam int COUNT_BITS   = spc_pkg::COUNT_BITS;
  localparam int TIME_BITS    = spc_pkg::TIME_BITS;
  localparam int DELTA_BITS   = spc_pkg::DELTA_BITS;
  localparam int CFG_BITS     = spc_pkg::CFG_BITS;
  localparam int CFG_IDX_BITS = spc_pkg::CFG_IDX_BITS;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_REPORTS    = 50;

  typedef struct {
    spc_pkg::op_t                 op;
    logic signed [DELTA_BITS-1:0] delta_x;
    logic signed [DELTA_BITS-1:0] delta_y;
    logic [AXIS_BITS-1:0]         axis;
    logic                         direction;
    logic [COUNT_BITS-1:0]        count;
    logic [TIME_BITS-1:0]         period;
    logic                         level;
  } cmd_item_t;

  typedef struct packed {
    logic [AXES-1:0] step;
    logic [AXES-1:0] dir;
    logic [AXES-1:0] en;
    spc_pkg::mode_t  mode;
    logic            busy;
    logic            idle;
  } line_state_t;

  typedef struct {
    cmd_item_t   cmd;
    bit          typed;
    line_state_t lines;
  } directed_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [2:0]                   in_op = 3'd0;
  logic signed [DELTA_BITS-1:0] in_delta_x = '0;
  logic signed [DELTA_BITS-1:0] in_delta_y = '0;
  logic [AXIS_BITS-1:0]         in_axis = '0;
  logic                         in_direction = 1'b0;
  logic [COUNT_BITS-1:0]        in_count = '0;
  logic [TIME_BITS-1:0]         in_period = '0;
  logic                         in_switch_level = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [AXES-1:0]              out_step_lines;
  logic [AXES-1:0]              out_direction_lines;
  logic [AXES-1:0]              out_enable_lines;
  logic [1:0]                   out_mode;
  logic                         out_xy_busy;
  logic                         out_all_idle;
  logic                         cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]      cfg_index = '0;
  logic [CFG_BITS-1:0]          cfg_data = '0;

  // predictor state
  logic [COUNT_BITS-1:0] want_cnt [AXES];
  logic [COUNT_BITS-1:0] done_cnt [AXES];
  logic [TIME_BITS-1:0]  axis_per [AXES];
  logic [TIME_BITS-1:0]  tick_cnt [AXES];
  logic                  rise_armed [AXES];
  logic [AXES-1:0]       step_q, dir_q, en_q;
  spc_pkg::mode_t        mode_q;
  logic [TIME_BITS-1:0]  min_period_r, high_time_r, fast_period_r;
  logic [COUNT_BITS-1:0] budget_r;

  line_state_t   expected_lines [$];
  directed_row_t directed_rows [$];

  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  stall_request = 1'b0;
  int  hold_left = 0;
  int  quiet_cycles = 0;
  int  items_sent = 0;
  int  items_total = 0;
  int  results_checked = 0;
  int  mismatch_count = 0;

  four_axis_stepper_pulse_controller_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_delta_x          (in_delta_x),
    .in_delta_y          (in_delta_y),
    .in_axis             (in_axis),
    .in_direction        (in_direction),
    .in_count            (in_count),
    .in_period           (in_period),
    .in_switch_level     (in_switch_level),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_step_lines      (out_step_lines),
    .out_direction_lines (out_direction_lines),
    .out_enable_lines    (out_enable_lines),
    .out_mode            (out_mode),
    .out_xy_busy         (out_xy_busy),
    .out_all_idle        (out_all_idle),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic bit axis_pending(input int a);
    return done_cnt[a] < want_cnt[a];
  endfunction

  function automatic int magnitude_of(input logic signed [DELTA_BITS-1:0] v);
    return (v < 0) ? -int'(v) : int'(v);
  endfunction

  // period of the slower axis, clamped to the timer width
  function automatic logic [TIME_BITS-1:0] slow_period(input int larger,
                                                       input int smaller);
    longint p;
    p = longint'(min_period_r) * larger / smaller;
    return (p > longint'(spc_pkg::TIME_MAX)) ? spc_pkg::TIME_MAX : TIME_BITS'(p);
  endfunction

  function automatic void load_axis(input int a, input logic d,
                                    input logic [COUNT_BITS-1:0] n,
                                    input logic [TIME_BITS-1:0] p);
    en_q[a]     = 1'b1;
    dir_q[a]    = d;
    want_cnt[a] = n;
    done_cnt[a] = '0;
    axis_per[a] = p;
  endfunction

  function automatic void stop_axis(input int a);
    want_cnt[a] = '0;
    done_cnt[a] = '0;
    en_q[a]     = 1'b0;
  endfunction

  function automatic line_state_t apply_cmd(input cmd_item_t c);
    int          a, sx, sy;
    logic [TIME_BITS-1:0] px, py;
    bit          err;
    line_state_t r;
    err = (mode_q == spc_pkg::MODE_ERROR);
    case (c.op)
      spc_pkg::OP_TICK: begin
        for (a = 0; a < AXES; a++) begin
          if (tick_cnt[a] != spc_pkg::TIME_MAX) tick_cnt[a] = tick_cnt[a] + 1'b1;
          if (want_cnt[a] != 0 && axis_pending(a) && tick_cnt[a] > high_time_r) begin
            if (rise_armed[a]) begin
              rise_armed[a] = 1'b0;
              tick_cnt[a]   = '0;
              step_q[a]     = 1'b1;
              done_cnt[a]   = done_cnt[a] + 1'b1;
            end else if (tick_cnt[a] > axis_per[a]) begin
              rise_armed[a] = 1'b1;
              tick_cnt[a]   = '0;
              step_q[a]     = 1'b0;
            end
          end
        end
      end
      spc_pkg::OP_MOVE: begin
        sx = magnitude_of(c.delta_x);
        sy = magnitude_of(c.delta_y);
        px = min_period_r;
        py = min_period_r;
        if (!err && (sx != 0 || sy != 0)) begin
          if (sy > sx && sx != 0) px = slow_period(sy, sx);
          else if (sx > sy && sy != 0) py = slow_period(sx, sy);
          // positive delta drives level 0, zero or negative level 1
          load_axis(spc_pkg::AXIS_X, (c.delta_x < 0 || sx == 0), COUNT_BITS'(sx), px);
          load_axis(spc_pkg::AXIS_Y, (c.delta_y < 0 || sy == 0), COUNT_BITS'(sy), py);
        end
      end
      spc_pkg::OP_RUN: begin
        if (!err) load_axis(c.axis, c.direction, c.count, c.period);
      end
      spc_pkg::OP_STOP: stop_axis(c.axis);
      spc_pkg::OP_LIMIT: begin
        if (c.level) begin
          if (mode_q == spc_pkg::MODE_HOMING) begin
            case (c.axis)
              spc_pkg::AXIS_X: begin
                stop_axis(spc_pkg::AXIS_X);
                load_axis(spc_pkg::AXIS_Y, 1'b1, budget_r, fast_period_r);
              end
              spc_pkg::AXIS_Y: begin
                stop_axis(spc_pkg::AXIS_Y);
                load_axis(spc_pkg::AXIS_Z, 1'b1, budget_r, fast_period_r);
              end
              spc_pkg::AXIS_Z: begin
                stop_axis(spc_pkg::AXIS_Z);
                mode_q = spc_pkg::MODE_HOMED;
              end
              default: ;
            endcase
          end else if (mode_q == spc_pkg::MODE_RUN) begin
            mode_q = spc_pkg::MODE_ERROR;
            for (a = 0; a < AXES; a++) begin
              want_cnt[a] = '0;
              done_cnt[a] = '0;
            end
            en_q = '0;
          end
        end
      end
      spc_pkg::OP_HOME: begin
        if (!err) begin
          mode_q = spc_pkg::MODE_HOMING;
          load_axis(spc_pkg::AXIS_X, 1'b0, budget_r, fast_period_r);
        end
      end
      spc_pkg::OP_CLEAR: begin
        if (err) mode_q = spc_pkg::MODE_RUN;
      end
      default: ;
    endcase
    r.step = step_q;
    r.dir  = dir_q;
    r.en   = en_q;
    r.mode = mode_q;
    r.busy = axis_pending(0) || axis_pending(1);
    r.idle = 1'b1;
    for (a = 0; a < AXES; a++) if (axis_pending(a)) r.idle = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_REPORTS)
      $display("%0t: result %0d %s mismatch: got %0h want %0h",
               $realtime, results_checked, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_cmd(input cmd_item_t c, input bit typed, input line_state_t lines);
    line_state_t predicted;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= c.op;
    in_delta_x      <= c.delta_x;
    in_delta_y      <= c.delta_y;
    in_axis         <= c.axis;
    in_direction    <= c.direction;
    in_count        <= c.count;
    in_period       <= c.period;
    in_switch_level <= c.level;
    do @(posedge clk); while (!in_ready);
    predicted = apply_cmd(c);
    expected_lines.push_back(typed ? lines : predicted);
    items_total++;
    if (c.op != spc_pkg::OP_NONE && c.op != spc_pkg::OP_CLEAR) items_sent++;
  endtask

  task automatic write_reg(input spc_pkg::cfg_reg_t idx, input logic [CFG_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      spc_pkg::REG_MIN_PERIOD:   min_period_r  = value[TIME_BITS-1:0];
      spc_pkg::REG_PULSE_HIGH:   high_time_r   = value[TIME_BITS-1:0];
      spc_pkg::REG_FAST_PERIOD:  fast_period_r = value[TIME_BITS-1:0];
      spc_pkg::REG_HOMING_COUNT: budget_r      = value[COUNT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input int minp, input int high, input int fast,
                              input int budget);
    write_reg(spc_pkg::REG_MIN_PERIOD, CFG_BITS'(minp));
    write_reg(spc_pkg::REG_PULSE_HIGH, CFG_BITS'(high));
    write_reg(spc_pkg::REG_FAST_PERIOD, CFG_BITS'(fast));
    write_reg(spc_pkg::REG_HOMING_COUNT, CFG_BITS'(budget));
    cfg_we <= 1'b0;
  endtask

  // wait until every expected result is back and the divider has surely settled
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic cmd_item_t random_fields();
    cmd_item_t c;
    c.op        = spc_pkg::OP_TICK;
    c.delta_x   = DELTA_BITS'(int'($urandom_range(0, 65534)) - 32767);
    c.delta_y   = DELTA_BITS'(int'($urandom_range(0, 65534)) - 32767);
    c.axis      = AXIS_BITS'($urandom_range(0, AXES - 1));
    c.direction = 1'($urandom_range(0, 1));
    c.count     = COUNT_BITS'($urandom());
    c.period    = TIME_BITS'($urandom());
    c.level     = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic send_random_cmd();
    cmd_item_t c;
    int        r;
    c = random_fields();
    r = $urandom_range(99);
    if (r < 62) begin
      c.op = spc_pkg::OP_TICK;
    end else if (r < 70) begin
      c.op = spc_pkg::OP_MOVE;
      // mostly short moves so that they finish within the phase
      if ($urandom_range(99) < 80) begin
        c.delta_x = DELTA_BITS'(int'($urandom_range(0, 12)) - 6);
        c.delta_y = DELTA_BITS'(int'($urandom_range(0, 12)) - 6);
      end
    end else if (r < 79) begin
      c.op = spc_pkg::OP_RUN;
      if ($urandom_range(99) < 75) c.count = COUNT_BITS'($urandom_range(0, 5));
      r = $urandom_range(99);
      if (r < 10) c.period = '0;
      else if (r < 70) c.period = TIME_BITS'($urandom_range(1, 4));
    end else if (r < 83) begin
      c.op = spc_pkg::OP_STOP;
    end else if (r < 90) begin
      c.op = spc_pkg::OP_LIMIT;
    end else if (r < 94) begin
      c.op = spc_pkg::OP_HOME;
    end else if (r < 96) begin
      c.op = spc_pkg::OP_CLEAR;
    end else if (r < 98) begin
      c.op = spc_pkg::OP_NONE;
    end
    send_cmd(c, 1'b0, '0);
  endtask

  // start homing, then press x, y and z limits with a few ticks in between
  task automatic run_homing_chain();
    cmd_item_t c;
    int        ax;
    c = random_fields();
    c.op = spc_pkg::OP_HOME;
    send_cmd(c, 1'b0, '0);
    for (ax = 0; ax < 3; ax++) begin
      repeat ($urandom_range(0, 6)) begin
        c = random_fields();
        c.op = spc_pkg::OP_TICK;
        send_cmd(c, 1'b0, '0);
      end
      c = random_fields();
      c.op    = spc_pkg::OP_LIMIT;
      c.axis  = AXIS_BITS'(ax);
      c.level = 1'b1;
      send_cmd(c, 1'b0, '0);
    end
  endtask

  task automatic run_random_phase(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(99) < 4) run_homing_chain();
      else send_random_cmd();
    end
  endtask

  function automatic void add_row(input spc_pkg::op_t op, input int dx, input int dy,
                                  input int ax, input bit d, input int n, input int p,
                                  input bit lvl);
    directed_row_t row;
    row.cmd.op        = op;
    row.cmd.delta_x   = DELTA_BITS'(dx);
    row.cmd.delta_y   = DELTA_BITS'(dy);
    row.cmd.axis      = AXIS_BITS'(ax);
    row.cmd.direction = d;
    row.cmd.count     = COUNT_BITS'(n);
    row.cmd.period    = TIME_BITS'(p);
    row.cmd.level     = lvl;
    row.typed         = 1'b0;
    row.lines         = '0;
    directed_rows.push_back(row);
  endfunction

  // pin the expected lines of the last row added
  function automatic void set_lines(input logic [AXES-1:0] step, input logic [AXES-1:0] dir,
                                    input logic [AXES-1:0] en, input spc_pkg::mode_t mode,
                                    input logic busy, input logic idle);
    int last;
    last = directed_rows.size() - 1;
    directed_rows[last].typed = 1'b1;
    directed_rows[last].lines = '{step: step, dir: dir, en: en, mode: mode,
                                  busy: busy, idle: idle};
  endfunction

  // ---------------------------------------------------------------- receiving

  initial begin
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        hold_left     = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    line_state_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_lines.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        want = expected_lines.pop_front();
        if (out_step_lines != want.step)
          report_mismatch("step_lines", out_step_lines, want.step);
        if (out_direction_lines != want.dir)
          report_mismatch("direction_lines", out_direction_lines, want.dir);
        if (out_enable_lines != want.en)
          report_mismatch("enable_lines", out_enable_lines, want.en);
        if (out_mode != want.mode) report_mismatch("mode", out_mode, want.mode);
        if (out_xy_busy != want.busy) report_mismatch("xy_busy", out_xy_busy, want.busy);
        if (out_all_idle != want.idle) report_mismatch("all_idle", out_all_idle, want.idle);
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no item moved for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_lines.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    for (int a = 0; a < AXES; a++) begin
      want_cnt[a]   = '0;
      done_cnt[a]   = '0;
      axis_per[a]   = spc_pkg::MIN_PERIOD_RST;
      tick_cnt[a]   = '0;
      rise_armed[a] = 1'b1;
    end
    step_q        = '0;
    dir_q         = '0;
    en_q          = '0;
    mode_q        = spc_pkg::MODE_RUN;
    min_period_r  = spc_pkg::MIN_PERIOD_RST;
    high_time_r   = spc_pkg::PULSE_HIGH_RST;
    fast_period_r = spc_pkg::FAST_PERIOD_RST;
    budget_r      = spc_pkg::HOMING_COUNT_RST;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(spc_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0);
    set_lines(4'h0, 4'h0, 4'h0, spc_pkg::MODE_RUN, 1'b0, 1'b1);
    add_row(spc_pkg::OP_NONE, 0, 0, 0, 0, 0, 0, 0);
    set_lines(4'h0, 4'h0, 4'h0, spc_pkg::MODE_RUN, 1'b0, 1'b1);
    add_row(spc_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);          // no error pending: ignored
    set_lines(4'h0, 4'h0, 4'h0, spc_pkg::MODE_RUN, 1'b0, 1'b1);
    add_row(spc_pkg::OP_MOVE, 0, 0, 0, 0, 0, 0, 0);           // empty move
    set_lines(4'h0, 4'h0, 4'h0, spc_pkg::MODE_RUN, 1'b0, 1'b1);
    add_row(spc_pkg::OP_MOVE, 32767, -32767, 0, 0, 0, 0, 0);  // equal counts
    set_lines(4'h0, 4'b0010, 4'b0011, spc_pkg::MODE_RUN, 1'b1, 1'b0);
    add_row(spc_pkg::OP_MOVE, -1, 32767, 0, 0, 0, 0, 0);      // stretched period clamps
    add_row(spc_pkg::OP_MOVE, 5, 0, 0, 0, 0, 0, 0);
    add_row(spc_pkg::OP_MOVE, -32767, 3, 0, 0, 0, 0, 0);
    add_row(spc_pkg::OP_RUN, 0, 0, 3, 1, 1048575, 65535, 0);
    add_row(spc_pkg::OP_RUN, 0, 0, 2, 1, 0, 0, 0);
    add_row(spc_pkg::OP_RUN, 0, 0, 1, 0, 3, 0, 0);            // zero period
    add_row(spc_pkg::OP_STOP, 0, 0, 3, 0, 0, 0, 0);
    add_row(spc_pkg::OP_LIMIT, 0, 0, 1, 0, 0, 0, 0);          // release in guarded run
    add_row(spc_pkg::OP_LIMIT, 0, 0, 3, 0, 0, 0, 1);          // guarded-run hit: error
    add_row(spc_pkg::OP_MOVE, 7, -2, 0, 0, 0, 0, 0);
    add_row(spc_pkg::OP_RUN, 0, 0, 0, 1, 9, 4, 0);
    add_row(spc_pkg::OP_HOME, 0, 0, 0, 0, 0, 0, 0);
    add_row(spc_pkg::OP_STOP, 0, 0, 2, 0, 0, 0, 0);
    add_row(spc_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    add_row(spc_pkg::OP_HOME, 0, 0, 0, 0, 0, 0, 0);
    add_row(spc_pkg::OP_LIMIT, 0, 0, 3, 0, 0, 0, 1);          // axis 3 limit while homing: ignored
    add_row(spc_pkg::OP_LIMIT, 0, 0, 0, 0, 0, 0, 0);
    add_row(spc_pkg::OP_LIMIT, 0, 0, 0, 0, 0, 0, 1);
    add_row(spc_pkg::OP_LIMIT, 0, 0, 1, 0, 0, 0, 1);
    add_row(spc_pkg::OP_LIMIT, 0, 0, 2, 0, 0, 0, 1);
    add_row(spc_pkg::OP_LIMIT, 0, 0, 0, 0, 0, 0, 1);          // homed: ignored

    tx_idle_pct = 10;
    rx_idle_pct = 79;
    foreach (directed_rows[i])
      send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].lines);

    run_random_phase(200);

    finish_phase();
    program_regs(2, 1, 3, 4);
    run_random_phase(300);

    finish_phase();
    program_regs(1, 1, 1, 1);
    tx_idle_pct = 79;
    rx_idle_pct = 10;
    run_random_phase(250);

    finish_phase();
    program_regs(65535, 2, 65535, 1048575);
    run_random_phase(200);

    finish_phase();
    program_regs(5, 65535, 2, 3);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random_phase(150);

    finish_phase();
    program_regs($urandom_range(1, 8), $urandom_range(1, 4), $urandom_range(1, 6),
                 $urandom_range(1, 12));
    run_random_phase(300);

    finish_phase();
    program_regs($urandom_range(1, 8), $urandom_range(1, 4), $urandom_range(1, 6),
                 $urandom_range(1, 12));
    stall_request = 1'b1;   // long output back-pressure while input keeps coming
    run_random_phase(300);

    finish_phase();
    $display("Run summary: %0d items in, %0d results compared, 7 register settings",
             items_total, results_checked);
    $display("Exercised moves with stretched periods, runs, stops, error and recovery, homing");
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
